// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the key state tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/kset_pkg.sv -----
// Package with the operation codes of the key state tracker.
package kset_pkg;

	typedef enum logic [2:0] {
		OP_KEY_DOWN = 3'd0,
		OP_KEY_UP   = 3'd1,
		OP_CHAR     = 3'd2,
		OP_FRAME    = 3'd3,
		OP_CLEAR    = 3'd4,
		OP_POP      = 3'd5,
		OP_QUERY    = 3'd6
	} op_t;

	localparam int KEY_COUNT = 256;
	localparam int CODE_W    = 8;

endpackage

// ----- rtl/key_state_edge_tracker_top.sv -----
// Top level of the key state tracker with its character queue.
// The block accepts one transaction per clock cycle while the output is not stalled and
// returns exactly one result for each. A transaction is captured in an input register, and
// the map and queue updates are computed in a single pass into the result register when the
// output is free to take them; the result is offered from that register until it is taken.
// The three key maps are flip-flop vectors cleared at once by reset, by a clear transaction
// and, for the pressed and released maps, by a new-frame transaction; no clearing pass is
// needed. The character queue is a small memory with a registered read port that always
// holds the entry at the current read pointer.
`include "assert_macros.svh"

module key_state_edge_tracker_top
	import kset_pkg::*;
#(
	parameter int CHAR_QUEUE_DEPTH = 16,
	localparam int PTR_W = (CHAR_QUEUE_DEPTH > 1) ? $clog2(CHAR_QUEUE_DEPTH) : 1,
	localparam int CNT_W = $clog2(CHAR_QUEUE_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        op,
	input  logic [CODE_W-1:0] code,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              key_held,
	output logic              key_pressed,
	output logic              key_released,
	output logic [7:0]        char_out,
	output logic              char_available,
	output logic [CNT_W-1:0]  queue_count
);

	logic                  valid_s1;
	op_t                   op_s1;
	logic [CODE_W-1:0]     code_s1;
	logic                  advance;

	logic [KEY_COUNT-1:0]  held_q, pressed_q, released_q;
	logic [KEY_COUNT-1:0]  held_d, pressed_d, released_d;
	logic [PTR_W-1:0]      rd_ptr_q, wr_ptr_q, rd_ptr_d, wr_ptr_d, rd_addr;
	logic [CNT_W-1:0]      count_q, count_d;
	logic                  push;
	logic                  push_we;
	logic [7:0]            char_d;

	logic [7:0]            char_mem [CHAR_QUEUE_DEPTH];
	logic [7:0]            rd_data_q;

	logic                  out_valid_q;
	logic                  key_held_q, key_pressed_q, key_released_q;
	logic [7:0]            char_out_q;
	logic                  char_available_q;
	logic [CNT_W-1:0]      queue_count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(CHAR_QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op_t'(op);
			code_s1 <= code;
		end
	end

	always_comb begin
		held_d     = held_q;
		pressed_d  = pressed_q;
		released_d = released_q;
		rd_ptr_d   = rd_ptr_q;
		wr_ptr_d   = wr_ptr_q;
		count_d    = count_q;
		push       = 1'b0;
		char_d     = '0;
		unique case (op_s1)
			OP_KEY_DOWN: begin
				if (!held_q[code_s1]) begin
					held_d[code_s1]    = 1'b1;
					pressed_d[code_s1] = 1'b1;
				end
			end
			OP_KEY_UP: begin
				if (held_q[code_s1]) begin
					held_d[code_s1]     = 1'b0;
					released_d[code_s1] = 1'b1;
				end
			end
			OP_CHAR: begin
				push     = 1'b1;
				wr_ptr_d = ptr_inc(wr_ptr_q);
				if (count_q == CNT_W'(CHAR_QUEUE_DEPTH)) begin
					rd_ptr_d = ptr_inc(rd_ptr_q);
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			OP_FRAME: begin
				pressed_d  = '0;
				released_d = '0;
			end
			OP_CLEAR: begin
				held_d     = '0;
				pressed_d  = '0;
				released_d = '0;
				rd_ptr_d   = '0;
				wr_ptr_d   = '0;
				count_d    = '0;
			end
			OP_POP: begin
				if (count_q != '0) begin
					char_d   = rd_data_q;
					rd_ptr_d = ptr_inc(rd_ptr_q);
					count_d  = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign push_we = advance && push;
	assign rd_addr = advance ? rd_ptr_d : rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			pressed_q  <= '0;
			released_q <= '0;
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			count_q    <= '0;
		end else if (advance) begin
			held_q     <= held_d;
			pressed_q  <= pressed_d;
			released_q <= released_d;
			rd_ptr_q   <= rd_ptr_d;
			wr_ptr_q   <= wr_ptr_d;
			count_q    <= count_d;
		end
	end

	// The read port tracks the read pointer, forwarding a byte written to that same slot.
	always_ff @(posedge clk) begin
		if (push_we) begin
			char_mem[wr_ptr_q] <= code_s1;
		end
		if (push_we && (wr_ptr_q == rd_addr)) begin
			rd_data_q <= code_s1;
		end else begin
			rd_data_q <= char_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= advance || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_held_q       <= held_d[code_s1];
			key_pressed_q    <= pressed_d[code_s1];
			key_released_q   <= released_d[code_s1];
			char_out_q       <= char_d;
			char_available_q <= (count_d != '0);
			queue_count_q    <= count_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign key_held       = key_held_q;
	assign key_pressed    = key_pressed_q;
	assign key_released   = key_released_q;
	assign char_out       = char_out_q;
	assign char_available = char_available_q;
	assign queue_count    = queue_count_q;

	`ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(CHAR_QUEUE_DEPTH), "queue count overflow")
	`ASSERT_IMPL(a_avail_match, out_valid_q, char_available_q == (queue_count_q != '0), "char_available mismatch")
	`ASSERT_NEXT(a_down_holds, advance && (op_s1 == OP_KEY_DOWN), key_held_q, "key down not held")
	`ASSERT_IMPL(a_stall_blocks, valid_s1 && out_valid_q && !out_ready, !in_ready, "input taken during stall")

endmodule

// ----- sim/key_state_edge_tracker_top_tb.sv -----
// Testbench for the key state tracker: key map and character queue results checked per transaction.
`timescale 1ns / 100ps

package key_tracker_tb_pkg;
	import kset_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	typedef struct packed {
		logic       held;
		logic       pressed;
		logic       released;
		logic [7:0] popped;
		logic       avail;
		logic [4:0] count;
	} key_report_t;

	class key_tracker_scoreboard;
		bit [255:0]  held_keys;
		bit [255:0]  pressed_keys;
		bit [255:0]  released_keys;
		bit [7:0]    char_ring [QUEUE_DEPTH];
		int unsigned rd_slot;
		int unsigned wr_slot;
		int unsigned char_fill;
		key_report_t owed_reports[$];
		int          mismatch_count;

		function void note_event(logic [2:0] opc, logic [7:0] key);
			key_report_t r;
			bit [7:0]    popped;
			popped = 8'd0;
			case (opc)
				OP_KEY_DOWN: begin
					if (!held_keys[key]) begin
						held_keys[key] = 1'b1;
						pressed_keys[key] = 1'b1;
					end
				end
				OP_KEY_UP: begin
					if (held_keys[key]) begin
						held_keys[key] = 1'b0;
						released_keys[key] = 1'b1;
					end
				end
				OP_CHAR: begin
					if (char_fill >= QUEUE_DEPTH) begin
						rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
						char_fill--;
					end
					char_ring[wr_slot] = key;
					wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
					char_fill++;
				end
				OP_FRAME: begin
					pressed_keys = '0;
					released_keys = '0;
				end
				OP_CLEAR: begin
					held_keys = '0;
					pressed_keys = '0;
					released_keys = '0;
					rd_slot = 0;
					wr_slot = 0;
					char_fill = 0;
				end
				OP_POP: begin
					if (char_fill != 0) begin
						popped = char_ring[rd_slot];
						rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
						char_fill--;
					end
				end
				default: ;
			endcase
			r.held = held_keys[key];
			r.pressed = pressed_keys[key];
			r.released = released_keys[key];
			r.popped = popped;
			r.avail = (char_fill != 0);
			r.count = 5'(char_fill);
			owed_reports.push_back(r);
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatch_count++;
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
			end
		endfunction

		function void check_report(key_report_t got);
			key_report_t want;
			if (owed_reports.size() == 0) begin
				mismatch_count++;
				$display("%0t: result arrived with no transaction pending", $time);
				return;
			end
			want = owed_reports.pop_front();
			compare_field("key_held", want.held, got.held);
			compare_field("key_pressed", want.pressed, got.pressed);
			compare_field("key_released", want.released, got.released);
			compare_field("char_out", want.popped, got.popped);
			compare_field("char_available", want.avail, got.avail);
			compare_field("queue_count", want.count, got.count);
		endfunction

		function int pending();
			return owed_reports.size();
		endfunction
	endclass
endpackage

module key_state_edge_tracker_top_tb;
	import kset_pkg::*;
	import key_tracker_tb_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [2:0] op = 3'd0;
	logic [7:0] code = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       key_held;
	logic       key_pressed;
	logic       key_released;
	logic [7:0] char_out;
	logic       char_available;
	logic [4:0] queue_count;

	key_tracker_scoreboard board = new();
	int sent_count = 0;
	int send_max_gap = 4;
	int recv_max_stall = 4;

	key_state_edge_tracker_top #(.CHAR_QUEUE_DEPTH(QUEUE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.code(code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.key_held(key_held),
		.key_pressed(key_pressed),
		.key_released(key_released),
		.char_out(char_out),
		.char_available(char_available),
		.queue_count(queue_count)
	);

	always #5 clk = ~clk;

	task automatic send_event(input logic [2:0] opc, input logic [7:0] key);
		int gap;
		gap = $urandom_range(send_max_gap, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= opc;
		code <= key;
		do @(posedge clk); while (!in_ready);
		board.note_event(opc, key);
		sent_count++;
	endtask

	task automatic send_key_burst();
		int         n;
		int         pick;
		logic [7:0] base_key;
		logic [7:0] key;
		n = $urandom_range(12, 4);
		base_key = 8'($urandom_range(255, 0));
		for (int i = 0; i < n; i++) begin
			key = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(255, 0))
				: 8'(base_key + $urandom_range(3, 0));
			pick = $urandom_range(9, 0);
			if (pick < 4)
				send_event(OP_KEY_DOWN, key);
			else if (pick < 7)
				send_event(OP_KEY_UP, key);
			else if (pick == 7)
				send_event(OP_QUERY, key);
			else if (pick == 8)
				send_event(OP_FRAME, key);
			else
				send_event(OP_POP, key);
		end
	endtask

	task automatic send_char_burst();
		int pushes;
		int pops;
		pushes = $urandom_range(20, 1);
		pops = $urandom_range(20, 0);
		repeat (pushes) send_event(OP_CHAR, 8'($urandom_range(255, 0)));
		repeat (pops) send_event(OP_POP, 8'($urandom_range(255, 0)));
	endtask

	initial begin
		int  pick;
		bit  drained;
		drained = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_event(OP_KEY_DOWN, 8'd0);
		send_event(OP_KEY_DOWN, 8'd255);
		send_event(OP_KEY_DOWN, 8'd0);
		send_event(OP_QUERY, 8'd0);
		send_event(OP_KEY_UP, 8'd255);
		send_event(OP_KEY_UP, 8'd255);
		send_event(OP_KEY_UP, 8'd7);
		send_event(OP_FRAME, 8'd255);
		send_event(OP_QUERY, 8'd255);
		send_event(OP_POP, 8'd0);
		send_event(OP_CHAR, 8'h00);
		send_event(OP_CHAR, 8'hFF);
		send_event(OP_CHAR, 8'hA5);
		send_event(OP_QUERY, 8'd0);
		send_event(OP_POP, 8'd0);
		send_event(OP_UNUSED, 8'd0);
		send_event(OP_POP, 8'd255);
		send_event(OP_KEY_DOWN, 8'h5A);
		send_event(OP_CLEAR, 8'd0);
		send_event(OP_POP, 8'd0);
		send_event(OP_QUERY, 8'h5A);

		while (sent_count < 450) begin
			send_max_gap = ($urandom_range(3, 0) == 0) ? 0 : 4;
			if (!drained && sent_count >= 300) begin
				drained = 1'b1;
				in_valid <= 1'b0;
				while (board.pending() != 0) @(posedge clk);
			end
			pick = $urandom_range(99, 0);
			if (pick < 55)
				send_key_burst();
			else if (pick < 85)
				send_char_burst();
			else if (pick < 92)
				send_event(OP_CLEAR, 8'($urandom_range(255, 0)));
			else
				repeat ($urandom_range(4, 1))
					send_event(3'($urandom_range(6, 0)), 8'($urandom_range(255, 0)));
		end
		in_valid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (board.mismatch_count == 0)
			$display("[key_state_edge_tracker_top] OK");
		else
			$display("[key_state_edge_tracker_top] ERROR");
		$finish;
	end

	initial begin
		int stall;
		int taken;
		taken = 0;
		forever begin
			stall = (taken == 120) ? 80 : $urandom_range(recv_max_stall, 0);
			if ($urandom_range(39, 0) == 0)
				recv_max_stall = (recv_max_stall == 0) ? 4 : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			board.check_report(key_report_t'{key_held, key_pressed, key_released,
				char_out, char_available, queue_count});
			taken++;
		end
	end

	initial begin
		#500000;
		$display("[key_state_edge_tracker_top] ERROR");
		$finish;
	end

endmodule
